// ===== rtl/core/bsdu_pkg.sv =====
// Package for the box signed distance update core.
// Holds request/result types, configuration indexes and the sqrt pipeline tag.
// No dependencies.
package bsdu_pkg;

  localparam int unsigned RootBits = 34;
  localparam int unsigned RadBits  = 66;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] stored_distance;
  } request_t;

  typedef struct packed {
    logic signed [31:0] new_distance;
    logic               replaced;
  } result_t;

  typedef enum logic [2:0] {
    CFG_BOX_MIN_X = 3'd0,
    CFG_BOX_MIN_Y = 3'd1,
    CFG_BOX_MIN_Z = 3'd2,
    CFG_BOX_MAX_X = 3'd3,
    CFG_BOX_MAX_Y = 3'd4,
    CFG_BOX_MAX_Z = 3'd5,
    CFG_INV_RES   = 3'd6
  } cfg_index_t;

  localparam logic [31:0] BoxMinReset = 32'd0;
  localparam logic [31:0] BoxMaxReset = 32'd65536;
  localparam logic [31:0] InvResReset = 32'd65536;

  typedef struct packed {
    logic signed [31:0] stored;
    logic               outside;
    logic [31:0]        face;
  } tag_t;

endpackage

// ===== rtl/core/bsdu_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Carries a tag alongside each radicand. Depends on bsdu_pkg.
module bsdu_sqrt
  import bsdu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [RadBits-1:0]    radicand,
  input  tag_t                  in_tag,
  output logic                  out_valid,
  output logic [RootBits-1:0]   root,
  output tag_t                  out_tag
);

  localparam int unsigned RemBits = 2 * RootBits;

  logic [RemBits-1:0]  rem_s  [0:RootBits];
  logic [RootBits-1:0] root_s [0:RootBits];
  logic                vld_s  [0:RootBits];
  tag_t                tag_s  [0:RootBits];

  assign rem_s[0]  = RemBits'(radicand);
  assign root_s[0] = '0;
  assign vld_s[0]  = in_valid;
  assign tag_s[0]  = in_tag;

  for (genvar k = 0; k < RootBits; k++) begin : g_stage
    localparam int unsigned B = RootBits - 1 - k;
    logic [RemBits-1:0] trial;
    logic               take;
    assign trial = (RemBits'(root_s[k]) << (B + 1)) | (RemBits'(1) << (2 * B));
    assign take  = rem_s[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vld_s[k];
      end
      tag_s[k+1]  <= tag_s[k];
      rem_s[k+1]  <= take ? rem_s[k] - trial : rem_s[k];
      root_s[k+1] <= take ? (root_s[k] | (RootBits'(1) << B)) : root_s[k];
    end
  end

  assign out_valid = vld_s[RootBits];
  assign root      = root_s[RootBits];
  assign out_tag   = tag_s[RootBits];

endmodule

// ===== rtl/core/box_signed_distance_update_core.sv =====
// An accepted request passes stages 1 to 3, the sqrt pipeline, the two scale registers and the result register.
// Throughput: one request per cycle; busy stays low, the 34-stage sqrt sets the depth.
// Synchronous active-high reset clears valid bits and restores box and scale registers.
// Results appear for one cycle with done; the receiver cannot stall.
// Depends on bsdu_pkg and bsdu_sqrt.
module box_signed_distance_update_core
  import bsdu_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  request_t    request,
  output logic        done,
  output result_t     result,
  input  logic        write_enable,
  input  logic [2:0]  write_index,
  input  logic [31:0] write_data
);

  logic signed [31:0] box_min [0:2];
  logic signed [31:0] box_max [0:2];
  logic [31:0]        inv_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_min[a] <= BoxMinReset;
        box_max[a] <= BoxMaxReset;
      end
      inv_res <= InvResReset;
    end else if (write_enable) begin
      unique case (cfg_index_t'(write_index))
        CFG_BOX_MIN_X: box_min[0] <= write_data;
        CFG_BOX_MIN_Y: box_min[1] <= write_data;
        CFG_BOX_MIN_Z: box_min[2] <= write_data;
        CFG_BOX_MAX_X: box_max[0] <= write_data;
        CFG_BOX_MAX_Y: box_max[1] <= write_data;
        CFG_BOX_MAX_Z: box_max[2] <= write_data;
        CFG_INV_RES:   inv_res    <= write_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic               accept;
  logic signed [31:0] pt [0:2];
  assign accept = start && !busy;
  assign pt[0]  = request.point_x;
  assign pt[1]  = request.point_y;
  assign pt[2]  = request.point_z;

  // stage 1: per-axis classification and gaps
  logic               s1_valid;
  logic [31:0]        s1_d   [0:2];
  logic [31:0]        s1_gap [0:2];
  logic [2:0]         s1_out;
  logic signed [31:0] s1_stored;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [32:0] lo_m_p, p_m_lo, p_m_hi, hi_m_p;
    logic               lt, gt;
    logic [31:0]        g1, g2;
    assign lo_m_p = 33'(box_min[a]) - 33'(pt[a]);
    assign p_m_lo = 33'(pt[a]) - 33'(box_min[a]);
    assign p_m_hi = 33'(pt[a]) - 33'(box_max[a]);
    assign hi_m_p = 33'(box_max[a]) - 33'(pt[a]);
    assign lt = pt[a] < box_min[a];
    assign gt = pt[a] > box_max[a];
    assign g1 = p_m_lo[31:0];
    assign g2 = hi_m_p[31:0];

    always_ff @(posedge clk) begin
      s1_out[a] <= lt || gt;
      s1_d[a]   <= lt ? lo_m_p[31:0] : (gt ? p_m_hi[31:0] : 32'd0);
      s1_gap[a] <= (lt || gt) ? 32'hFFFF_FFFF : ((g1 < g2) ? g1 : g2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_stored <= request.stored_distance;
  end

  // stage 2: squares and face minimum
  logic               s2_valid;
  logic [63:0]        s2_sq [0:2];
  logic               s2_out;
  logic [31:0]        s2_face;
  logic signed [31:0] s2_stored;
  logic [31:0]        face01;
  assign face01 = (s1_gap[0] < s1_gap[1]) ? s1_gap[0] : s1_gap[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    for (int a = 0; a < 3; a++) begin
      s2_sq[a] <= 64'(s1_d[a]) * 64'(s1_d[a]);
    end
    s2_out    <= |s1_out;
    s2_face   <= (face01 < s1_gap[2]) ? face01 : s1_gap[2];
    s2_stored <= s1_stored;
  end

  // stage 3: sum of squares
  logic               s3_valid;
  logic [RadBits-1:0] s3_sum;
  tag_t               s3_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_sum <= RadBits'(s2_sq[0]) + RadBits'(s2_sq[1]) + RadBits'(s2_sq[2]);
    s3_tag <= '{stored: s2_stored, outside: s2_out, face: s2_face};
  end

  logic                sq_valid;
  logic [RootBits-1:0] sq_root;
  tag_t                sq_tag;

  bsdu_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .radicand  (s3_sum),
    .in_tag    (s3_tag),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_tag   (sq_tag)
  );

  // scale: partial products, then sum
  logic [RootBits-1:0] mag;
  assign mag = sq_tag.outside ? sq_root : RootBits'(sq_tag.face);

  logic               m1_valid;
  logic [63:0]        m1_lo;
  logic [33:0]        m1_hi;
  logic               m1_neg;
  logic signed [31:0] m1_stored;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= sq_valid;
    end
    m1_lo     <= 64'(mag[31:0]) * 64'(inv_res);
    m1_hi     <= 34'(mag[RootBits-1:32]) * 34'(inv_res);
    m1_neg    <= !sq_tag.outside;
    m1_stored <= sq_tag.stored;
  end

  logic               m2_valid;
  logic [65:0]        m2_prod;
  logic               m2_neg;
  logic signed [31:0] m2_stored;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else begin
      m2_valid <= m1_valid;
    end
    m2_prod   <= 66'(m1_lo) + (66'(m1_hi) << 32);
    m2_neg    <= m1_neg;
    m2_stored <= m1_stored;
  end

  // saturate, compare, drive result
  logic [65:0] q_full;
  logic [31:0] q_sat, q_fin, smag;
  logic        take;
  assign q_full = m2_prod >> FRACTION_BITS;
  assign q_sat  = (q_full > 66'h0_8000_0000) ? 32'h8000_0000 : q_full[31:0];
  assign q_fin  = (!m2_neg && q_sat > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_sat;
  assign smag   = m2_stored[31] ? (32'd0 - m2_stored) : m2_stored;
  assign take   = q_fin < smag;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m2_valid;
    end
    result.replaced     <= take;
    result.new_distance <= take ? (m2_neg ? (32'd0 - q_fin) : q_fin) : m2_stored;
  end

endmodule

// ===== verif/bsdu_checker.sv =====
// Checker for box_signed_distance_update_core: mirrors the box and scale
// registers, predicts each result from accepted requests and compares.
// Depends on bsdu_pkg.
module bsdu_checker
  import bsdu_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  request_t    request,
  input  logic        done,
  input  result_t     result,
  input  logic        write_enable,
  input  logic [2:0]  write_index,
  input  logic [31:0] write_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];
  logic [31:0]        inv_res;
  result_t            expected_updates [$];

  function automatic result_t predict_update(request_t r);
    longint            p, lo, hi, g1, g2;
    longint unsigned   d, face;
    logic [67:0]       sum, c68;
    logic [33:0]       root, c;
    logic [65:0]       prod;
    logic [65:0]       q;
    logic [32:0]       smag;
    logic              outside, neg;
    logic signed [31:0] pt [3];
    result_t           res;
    pt[0] = r.point_x; pt[1] = r.point_y; pt[2] = r.point_z;
    sum = '0; face = 64'hFFFF_FFFF_FFFF_FFFF; outside = 1'b0;
    for (int a = 0; a < 3; a++) begin
      p = pt[a]; lo = box_lo[a]; hi = box_hi[a];
      if (p < lo || p > hi) begin
        d = (p < lo) ? longint'(lo - p) : longint'(p - hi);
        outside = 1'b1;
        sum = sum + ({36'b0, d[31:0]} * {36'b0, d[31:0]});
      end else begin
        g1 = p - lo; g2 = hi - p;
        d = (g1 < g2) ? g1 : g2;
        if (d < face) face = d;
      end
    end
    root = '0;
    if (outside) begin
      for (int b = 33; b >= 0; b--) begin
        c = root | (34'd1 << b);
        c68 = {34'b0, c} * {34'b0, c};
        if (c68 <= sum) root = c;
      end
      neg = 1'b0;
    end else begin
      root = face[33:0];
      neg = 1'b1;
    end
    prod = {32'b0, root} * {34'b0, inv_res};
    q = prod >> FRACTION_BITS;
    if (q > 66'h0_8000_0000) q = 66'h0_8000_0000;
    if (!neg && q > 66'h0_7FFF_FFFF) q = 66'h0_7FFF_FFFF;
    smag = r.stored_distance[31] ? 33'(-{1'b1, r.stored_distance})
                                 : {1'b0, r.stored_distance};
    if (q < {33'b0, smag}) begin
      res.new_distance = neg ? -q[31:0] : q[31:0];
      res.replaced = 1'b1;
    end else begin
      res.new_distance = r.stored_distance;
      res.replaced = 1'b0;
    end
    return res;
  endfunction

  assign pending = expected_updates.size();

  initial errors = 0;

  always @(posedge clk) begin
    result_t exp_res;
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_lo[a] <= BoxMinReset;
        box_hi[a] <= BoxMaxReset;
      end
      inv_res <= InvResReset;
      expected_updates.delete();
    end else begin
      if (start && !busy) expected_updates.push_back(predict_update(request));
      if (done) begin
        if (expected_updates.size() == 0) begin
          $error("unexpected result: new_distance=%0d replaced=%0b",
                 result.new_distance, result.replaced);
          errors++;
        end else begin
          exp_res = expected_updates.pop_front();
          if (result.new_distance !== exp_res.new_distance) begin
            $error("new_distance: expected %0d, actual %0d",
                   exp_res.new_distance, result.new_distance);
            errors++;
          end
          if (result.replaced !== exp_res.replaced) begin
            $error("replaced: expected %0b, actual %0b",
                   exp_res.replaced, result.replaced);
            errors++;
          end
        end
      end
      if (write_enable) begin
        case (cfg_index_t'(write_index))
          CFG_BOX_MIN_X: box_lo[0] <= write_data;
          CFG_BOX_MIN_Y: box_lo[1] <= write_data;
          CFG_BOX_MIN_Z: box_lo[2] <= write_data;
          CFG_BOX_MAX_X: box_hi[0] <= write_data;
          CFG_BOX_MAX_Y: box_hi[1] <= write_data;
          CFG_BOX_MAX_Z: box_hi[2] <= write_data;
          CFG_INV_RES:   inv_res <= write_data;
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== verif/tb_box_signed_distance_update_core.sv =====
// Testbench top for box_signed_distance_update_core: drives requests and
// register writes over several box settings; bsdu_checker does the checking.
// Depends on bsdu_pkg, bsdu_checker and the core.
module tb_box_signed_distance_update_core
  import bsdu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned DrainCycles = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  request_t    request = '0;
  logic        done;
  result_t     result;
  logic        write_enable = 1'b0;
  logic [2:0]  write_index = '0;
  logic [31:0] write_data = '0;
  int          errors;
  int          pending;
  int unsigned idle_cycles = 0;
  logic        no_gaps = 1'b0;
  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];

  always #4 clk = ~clk;

  box_signed_distance_update_core dut (
    .clk, .rst, .start, .busy, .request, .done, .result,
    .write_enable, .write_index, .write_data
  );

  bsdu_checker chk (
    .clk, .rst, .start, .busy, .request, .done, .result,
    .write_enable, .write_index, .write_data, .errors, .pending
  );

  always @(posedge clk) begin
    if ((start && !busy) || done || write_enable || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_point(request_t r);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) no_gaps = ~no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] data);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= data;
    @(posedge clk);
    write_enable <= 1'b0;
    if (idx <= CFG_BOX_MIN_Z) box_lo[idx] = data;
    else if (idx <= CFG_BOX_MAX_Z) box_hi[idx - CFG_BOX_MAX_X] = data;
  endtask

  task automatic set_box(logic [31:0] lo, logic [31:0] hi, logic [31:0] inv);
    write_reg(CFG_BOX_MIN_X, lo);
    write_reg(CFG_BOX_MIN_Y, lo + $urandom_range(0, 3));
    write_reg(CFG_BOX_MIN_Z, lo);
    write_reg(CFG_BOX_MAX_X, hi);
    write_reg(CFG_BOX_MAX_Y, hi);
    write_reg(CFG_BOX_MAX_Z, hi - $urandom_range(0, 3));
    write_reg(CFG_INV_RES, inv);
  endtask

  function automatic logic [31:0] pick_coord(int a);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return box_lo[a] + $urandom_range(0, 8) - 4;
      2: return box_hi[a] + $urandom_range(0, 8) - 4;
      3: return box_lo[a] + ($urandom() >> $urandom_range(8, 31));
      4: return box_hi[a] - ($urandom() >> $urandom_range(8, 31));
      default: return box_lo[a] + $urandom_range(0, 1 << 20) - (1 << 19);
    endcase
  endfunction

  function automatic request_t random_point();
    request_t r;
    r.point_x = pick_coord(0);
    r.point_y = pick_coord(1);
    r.point_z = pick_coord(2);
    case ($urandom_range(0, 3))
      0: r.stored_distance = $urandom();
      1: r.stored_distance = $urandom() >> $urandom_range(0, 31);
      2: r.stored_distance = -($urandom() >> $urandom_range(0, 31));
      default: r.stored_distance = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
    return r;
  endfunction

  task automatic random_phase(int n);
    repeat (n) send_point(random_point());
  endtask

  initial begin
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = BoxMinReset;
      box_hi[a] = BoxMaxReset;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset box: unit cube, unit scale
    send_point('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF});
    send_point('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000});
    send_point('{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh8000_0000});
    send_point('{0, 0, 0, 0});
    send_point('{0, 32'sd65536, 32'sd32768, 32'sh7FFF_FFFF});
    send_point('{32'sd32768, 32'sd32768, 32'sd32768, 32'sd32768});
    send_point('{32'sd32768, 32'sd32768, 32'sd32768, -32'sd32768});
    send_point('{32'sd32768, 32'sd32768, 32'sd32768, -32'sd32769});
    send_point('{32'sd131072, 32'sd32768, 32'sd32768, 32'sd65536});
    send_point('{32'sd131072, 32'sd32768, 32'sd32768, 32'sd65537});
    send_point('{-32'sd65536, -32'sd65536, -32'sd65536, 32'sh7FFF_FFFF});
    send_point('{32'sd65537, 32'sd32768, -32'sd1, 32'sh7FFF_FFFF});
    send_point('{32'shFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1});
    random_phase(120);

    // whole range box (Y min and Z max jittered): most points inside, large face gaps
    set_box(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_point('{0, 0, 0, 32'sh8000_0000});
    send_point('{-32'sd1, 0, 0, 32'sh8000_0000});
    send_point('{32'sh8000_0000, 0, 0, 32'sh8000_0000});
    random_phase(110);

    // inverted box, smallest scale
    set_box(32'sd100000, -32'sd100000, 32'd1);
    send_point('{0, 0, 0, 32'sd1});
    send_point('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    random_phase(110);

    // degenerate box at the negative extreme, largest scale
    set_box(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_point('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000});
    random_phase(110);

    for (int k = 0; k < 3; k++) begin
      set_box($urandom() >> 1 ^ 32'hC000_0000, $urandom() >> 4,
              $urandom() >> $urandom_range(0, 24) | 32'd1);
      random_phase(100);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
